// ===== rtl/chr_pkg.sv =====
// Shared types and constants for the connection handshake receiver.
// Used by every module under rtl; no dependencies.
`default_nettype none

package chr_pkg;

    localparam int TIMEOUT_WIDTH_DEF = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYN_CODE   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACK_CODE   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOSE_CODE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DATA_CODE  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_SEQ  = 3'd5;

    typedef enum logic [1:0] {
        OP_LISTEN = 2'd0,
        OP_ACCEPT = 2'd1,
        OP_BYTE   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        LS_CLOSED = 3'd0,
        LS_LISTEN = 3'd1,
        LS_SYNRCV = 3'd2,
        LS_PEND   = 3'd3,
        LS_OPEN   = 3'd4
    } link_t;

    typedef enum logic [2:0] {
        KIND_PAY   = 3'd0,
        KIND_ACK   = 3'd1,
        KIND_SYN   = 3'd2,
        KIND_CLOSE = 3'd3,
        KIND_STAT  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  syn_code;
        logic [7:0]  ack_code;
        logic [7:0]  close_code;
        logic [7:0]  data_code;
        logic [31:0] timeout_ticks;
        logic [7:0]  start_seq;
    } cfg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] src_node;
        logic [7:0] rx_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        status_t    status;
    } emit_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        status_t    status;
        link_t      conn_state;
        logic [7:0] peer_node;
        logic [7:0] peer_port;
        logic [7:0] peer_ack;
        logic       final_result;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/chr_cfg.sv =====
// Configuration register file for the handshake receiver.
// Depends on chr_pkg.
`default_nettype none

module chr_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [chr_pkg::CFG_INDEX_WIDTH-1:0]   wr_index,
    input  wire logic [chr_pkg::CFG_DATA_WIDTH-1:0]    wr_data,
    output chr_pkg::cfg_t                              cfg
);

    chr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.syn_code      <= 8'd1;
            cfg_reg.ack_code      <= 8'd2;
            cfg_reg.close_code    <= 8'd3;
            cfg_reg.data_code     <= 8'd4;
            cfg_reg.timeout_ticks <= 32'd1000;
            cfg_reg.start_seq     <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                chr_pkg::CFG_SYN_CODE:   cfg_reg.syn_code      <= wr_data[7:0];
                chr_pkg::CFG_ACK_CODE:   cfg_reg.ack_code      <= wr_data[7:0];
                chr_pkg::CFG_CLOSE_CODE: cfg_reg.close_code    <= wr_data[7:0];
                chr_pkg::CFG_DATA_CODE:  cfg_reg.data_code     <= wr_data[7:0];
                chr_pkg::CFG_TIMEOUT:    cfg_reg.timeout_ticks <= wr_data[31:0];
                chr_pkg::CFG_START_SEQ:  cfg_reg.start_seq     <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/chr_engine.sv =====
// Connection state registers and the single-pass step logic for one item.
// Depends on chr_pkg.
`default_nettype none

module chr_engine #(
    parameter int TIMEOUT_WIDTH = chr_pkg::TIMEOUT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  chr_pkg::cfg_t    cfg,
    input  chr_pkg::item_t   item,
    input  wire logic        fire,
    output logic [1:0]       res_cnt,
    output chr_pkg::res_t    res0,
    output chr_pkg::res_t    res1
);

    localparam int CW = (TIMEOUT_WIDTH > 32) ? TIMEOUT_WIDTH : 32;

    chr_pkg::link_t           link_reg, link_next;
    logic [7:0]               addr_reg, addr_next;
    logic [7:0]               seq_reg, seq_next;
    logic [7:0]               port_reg, port_next;
    logic [7:0]               rack_reg, rack_next;
    logic                     aw_reg, aw_next;
    logic [TIMEOUT_WIDTH-1:0] wc_reg, wc_next;
    logic [1:0]               bp_reg, bp_next;
    logic [7:0]               ct_reg, ct_next;
    logic [7:0]               cs_reg, cs_next;
    logic [7:0]               c3_reg, c3_next;
    logic                     sok_reg, sok_next;

    chr_pkg::emit_t           em [2];
    logic [1:0]               n;
    logic                     from_remote;
    logic                     active;
    logic [1:0]               idx;
    chr_pkg::link_t           lnk;
    logic [TIMEOUT_WIDTH-1:0] wc_tick;

    always_comb
    begin
        link_next   = link_reg;
        addr_next   = addr_reg;
        seq_next    = seq_reg;
        port_next   = port_reg;
        rack_next   = rack_reg;
        aw_next     = aw_reg;
        wc_next     = wc_reg;
        bp_next     = bp_reg;
        ct_next     = ct_reg;
        cs_next     = cs_reg;
        c3_next     = c3_reg;
        sok_next    = sok_reg;
        n           = 2'd0;
        em[0]       = '{kind: chr_pkg::KIND_STAT, value: 8'd0, status: chr_pkg::ST_OK};
        em[1]       = '{kind: chr_pkg::KIND_STAT, value: 8'd0, status: chr_pkg::ST_OK};
        from_remote = (item.src_node == addr_reg);
        active      = 1'b0;
        idx         = 2'd0;
        lnk         = link_reg;
        wc_tick     = wc_reg;

        unique case (item.operation)
            chr_pkg::OP_LISTEN:
            begin
                if (link_reg == chr_pkg::LS_CLOSED)
                begin
                    link_next = chr_pkg::LS_LISTEN;
                    em[n[0]] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                                 status: chr_pkg::ST_OK};
                end
                else
                begin
                    em[n[0]] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                                 status: chr_pkg::ST_BAD};
                end
                n = n + 2'd1;
            end
            chr_pkg::OP_ACCEPT:
            begin
                if (link_reg == chr_pkg::LS_SYNRCV)
                begin
                    em[0] = '{kind: chr_pkg::KIND_ACK, value: seq_reg,
                              status: chr_pkg::ST_OK};
                    em[1] = '{kind: chr_pkg::KIND_SYN, value: cfg.start_seq,
                              status: chr_pkg::ST_OK};
                    n = 2'd2;
                    link_next = chr_pkg::LS_PEND;
                    aw_next   = 1'b1;
                    wc_next   = '0;
                end
                else
                begin
                    em[0] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                              status: chr_pkg::ST_BAD};
                    n = 2'd1;
                end
            end
            chr_pkg::OP_BYTE:
            begin
                if (item.first_byte)
                begin
                    active   = 1'b1;
                    idx      = 2'd0;
                    ct_next  = item.rx_byte;
                    cs_next  = 8'd0;
                    c3_next  = 8'd0;
                    sok_next = 1'b0;
                end
                else if (bp_reg != 2'd0)
                begin
                    active = 1'b1;
                    idx    = bp_reg;
                end
                if (active)
                begin
                    if (idx == 2'd1)
                    begin
                        cs_next = item.rx_byte;
                    end
                    if (idx == 2'd2)
                    begin
                        c3_next = item.rx_byte;
                    end
                    if (item.last_byte)
                    begin
                        bp_next = 2'd0;
                    end
                    else if (idx == 2'd3)
                    begin
                        bp_next = 2'd3;
                    end
                    else
                    begin
                        bp_next = idx + 2'd1;
                    end
                    // in-order data while open
                    if (link_reg == chr_pkg::LS_OPEN && from_remote
                        && ct_next == cfg.data_code)
                    begin
                        if (idx == 2'd1 && item.rx_byte == seq_reg + 8'd1)
                        begin
                            seq_next = item.rx_byte;
                            sok_next = 1'b1;
                        end
                        if (idx >= 2'd2 && sok_next)
                        begin
                            em[n[0]] = '{kind: chr_pkg::KIND_PAY, value: item.rx_byte,
                                         status: chr_pkg::ST_OK};
                            n = n + 2'd1;
                        end
                    end
                    if (item.last_byte)
                    begin
                        unique case (link_reg)
                            chr_pkg::LS_LISTEN:
                            begin
                                if (ct_next == cfg.syn_code)
                                begin
                                    addr_next = item.src_node;
                                    seq_next  = cs_next;
                                    port_next = c3_next;
                                    link_next = chr_pkg::LS_SYNRCV;
                                end
                            end
                            chr_pkg::LS_SYNRCV:
                            begin
                                if (idx == 2'd1 && from_remote
                                    && ct_next == cfg.close_code)
                                begin
                                    link_next = chr_pkg::LS_CLOSED;
                                end
                            end
                            chr_pkg::LS_PEND:
                            begin
                                if (from_remote)
                                begin
                                    if (ct_next == cfg.ack_code)
                                    begin
                                        lnk = chr_pkg::LS_OPEN;
                                    end
                                    if (ct_next == cfg.close_code)
                                    begin
                                        lnk = chr_pkg::LS_CLOSED;
                                    end
                                    link_next = lnk;
                                    if (aw_reg && lnk == chr_pkg::LS_OPEN)
                                    begin
                                        aw_next = 1'b0;
                                        wc_next = '0;
                                        em[0] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                                                  status: chr_pkg::ST_OK};
                                        n = 2'd1;
                                    end
                                    else if (aw_reg && lnk == chr_pkg::LS_CLOSED)
                                    begin
                                        aw_next = 1'b0;
                                        wc_next = '0;
                                        em[0] = '{kind: chr_pkg::KIND_CLOSE, value: 8'd0,
                                                  status: chr_pkg::ST_OK};
                                        em[1] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                                                  status: chr_pkg::ST_BAD};
                                        n = 2'd2;
                                    end
                                end
                            end
                            chr_pkg::LS_OPEN:
                            begin
                                if (from_remote)
                                begin
                                    if (ct_next == cfg.close_code)
                                    begin
                                        link_next = chr_pkg::LS_CLOSED;
                                    end
                                    if (ct_next == cfg.ack_code)
                                    begin
                                        rack_next = cs_next;
                                    end
                                    if (ct_next == cfg.data_code)
                                    begin
                                        em[n[0]] = '{kind: chr_pkg::KIND_ACK,
                                                     value: seq_next,
                                                     status: chr_pkg::ST_OK};
                                        n = n + 2'd1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            chr_pkg::OP_TICK:
            begin
                if (aw_reg && link_reg == chr_pkg::LS_PEND)
                begin
                    if (wc_reg != '1)
                    begin
                        wc_tick = wc_reg + TIMEOUT_WIDTH'(1);
                    end
                    wc_next = wc_tick;
                    if (CW'(wc_tick) > CW'(cfg.timeout_ticks))
                    begin
                        link_next = chr_pkg::LS_CLOSED;
                        aw_next   = 1'b0;
                        wc_next   = '0;
                        em[0] = '{kind: chr_pkg::KIND_CLOSE, value: 8'd0,
                                  status: chr_pkg::ST_OK};
                        em[1] = '{kind: chr_pkg::KIND_STAT, value: 8'd0,
                                  status: chr_pkg::ST_TIMEOUT};
                        n = 2'd2;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        res0 = '{kind: em[0].kind, value: em[0].value, status: em[0].status,
                 conn_state: link_next, peer_node: addr_next, peer_port: port_next,
                 peer_ack: rack_next, final_result: (n == 2'd1)};
        res1 = '{kind: em[1].kind, value: em[1].value, status: em[1].status,
                 conn_state: link_next, peer_node: addr_next, peer_port: port_next,
                 peer_ack: rack_next, final_result: (n == 2'd2)};
    end

    assign res_cnt = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= chr_pkg::LS_CLOSED;
            addr_reg <= 8'd0;
            seq_reg  <= 8'd0;
            port_reg <= 8'd0;
            rack_reg <= 8'd0;
            aw_reg   <= 1'b0;
            wc_reg   <= '0;
            bp_reg   <= 2'd0;
            ct_reg   <= 8'd0;
            cs_reg   <= 8'd0;
            c3_reg   <= 8'd0;
            sok_reg  <= 1'b0;
        end
        else if (fire)
        begin
            link_reg <= link_next;
            addr_reg <= addr_next;
            seq_reg  <= seq_next;
            port_reg <= port_next;
            rack_reg <= rack_next;
            aw_reg   <= aw_next;
            wc_reg   <= wc_next;
            bp_reg   <= bp_next;
            ct_reg   <= ct_next;
            cs_reg   <= cs_next;
            c3_reg   <= c3_next;
            sok_reg  <= sok_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chr_res_q.sv =====
// Two-entry result queue: takes up to two results per cycle, hands out one.
// Depends on chr_pkg.
`default_nettype none

module chr_res_q (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  chr_pkg::res_t   push0,
    input  chr_pkg::res_t   push1,
    input  wire logic       pop,
    output logic [1:0]      free,
    output logic            head_valid,
    output chr_pkg::res_t   head
);

    chr_pkg::res_t ent_reg [chr_pkg::QUEUE_DEPTH];
    chr_pkg::res_t ent_next [chr_pkg::QUEUE_DEPTH];
    logic [1:0]    cnt_reg, cnt_next;
    logic [1:0]    rem;

    always_comb
    begin
        rem         = cnt_reg - {1'b0, pop};
        ent_next[0] = pop ? ent_reg[1] : ent_reg[0];
        ent_next[1] = ent_reg[1];
        if (rem == 2'd0)
        begin
            if (push_cnt != 2'd0)
            begin
                ent_next[0] = push0;
            end
            if (push_cnt == 2'd2)
            begin
                ent_next[1] = push1;
            end
        end
        else if (rem == 2'd1)
        begin
            if (push_cnt != 2'd0)
            begin
                ent_next[1] = push0;
            end
        end
        cnt_next = rem + push_cnt;
    end

    assign free       = 2'd2 - cnt_reg + {1'b0, pop};
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

`default_nettype wire

// ===== rtl/connection_handshake_receiver.sv =====
// Flow: an item is registered on accept and fires once the result queue has room for all
// its results, which the queue registers and offers on out_valid. Throughput: one item
// per cycle while items give at most one result and out_ready holds; two results leave
// one at a time through the single-entry output port of the queue.
// Reset: async active-low; link closed, records cleared, config regs to defaults.
// Depends on chr_pkg, chr_cfg, chr_engine, chr_res_q.
`default_nettype none

module connection_handshake_receiver #(
    parameter int TIMEOUT_WIDTH = chr_pkg::TIMEOUT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [chr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [chr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          operation,
    input  wire logic [7:0]                          src_node,
    input  wire logic [7:0]                          rx_byte,
    input  wire logic                                first_byte,
    input  wire logic                                last_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               kind,
    output logic [7:0]                               value,
    output logic [1:0]                               status,
    output logic [2:0]                               conn_state,
    output logic [7:0]                               peer_node,
    output logic [7:0]                               peer_port,
    output logic [7:0]                               peer_ack,
    output logic                                     final_result
);

    chr_pkg::cfg_t  cfg;
    chr_pkg::item_t item_reg;
    logic           inv_reg;
    logic           fire;
    logic [1:0]     res_cnt;
    chr_pkg::res_t  res0, res1;
    logic [1:0]     free;
    logic           pop;
    chr_pkg::res_t  head;

    assign cfg_ready = 1'b1;

    chr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign fire     = inv_reg && (res_cnt <= free);
    assign in_ready = !inv_reg || fire;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            inv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (in_ready && in_valid)
        begin
            item_reg.operation  <= chr_pkg::op_t'(operation);
            item_reg.src_node   <= src_node;
            item_reg.rx_byte    <= rx_byte;
            item_reg.first_byte <= first_byte;
            item_reg.last_byte  <= last_byte;
        end
    end

    chr_engine #(
        .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .fire    (fire),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    chr_res_q u_res_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (fire ? res_cnt : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .free       (free),
        .head_valid (out_valid),
        .head       (head)
    );

    assign kind         = head.kind;
    assign value        = head.value;
    assign status       = head.status;
    assign conn_state   = head.conn_state;
    assign peer_node    = head.peer_node;
    assign peer_port    = head.peer_port;
    assign peer_ack     = head.peer_ack;
    assign final_result = head.final_result;

endmodule

`default_nettype wire
